// File: rtl/rce_pkg.sv
// Package for the rotor cipher letter engine: opcodes, register indexes,
// wheel, notch and reflector tables, and the letter arithmetic helpers.
// No dependencies.
package rce_pkg;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_wheel;

    typedef enum logic [1:0] {
        OP_ENCODE = 2'd0,
        OP_UNDO   = 2'd1,
        OP_LOAD   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_ROTOR_ORDER  = 3'd0,
        CFG_RING         = 3'd1,
        CFG_START        = 3'd2,
        CFG_REFLECTOR    = 3'd3,
        CFG_PLUG_A       = 3'd4,
        CFG_PLUG_B       = 3'd5,
        CFG_PLUG_C       = 3'd6,
        CFG_SPARE        = 3'd7
    } t_cfg_index;

    localparam int      LETTERS     = 26;
    localparam int      WIRES       = 13;
    localparam int      CFG_DATA_W  = 50;
    localparam int      PLUG_W      = 10 * WIRES;
    localparam t_letter UNPLUGGED   = 5'd31;
    localparam t_letter LAST_LETTER = 5'd25;

    localparam logic [0:7][8*26-1:0] WHEEL_WIRING = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV"
    };

    localparam logic [0:1][8*26-1:0] REFLECTOR_WIRING = '{
        "YRUHQSLDPXNGOKMIEBFZCWVJAT",
        "FVPJIAOYEDRZXWGCTKUQSBNMHL"
    };

    // Two notch letters per wheel; single-notch wheels repeat theirs.
    localparam t_letter [0:7] NOTCH_A = '{
        5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd25, 5'd25, 5'd25
    };
    localparam t_letter [0:7] NOTCH_B = '{
        5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd12, 5'd12, 5'd12
    };

    function automatic t_letter clamp25(t_letter v);
        return (v > LAST_LETTER) ? LAST_LETTER : v;
    endfunction

    function automatic t_letter inc26(t_letter p);
        return (p >= LAST_LETTER) ? 5'd0 : 5'(p + 5'd1);
    endfunction

    function automatic t_letter add26(t_letter a, t_letter b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[4:0];
    endfunction

    function automatic t_letter sub26(t_letter a, t_letter b);
        logic [5:0] d;
        d = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
        return (a >= b) ? 5'(a - b) : d[4:0];
    endfunction

    function automatic logic at_notch(t_wheel w, t_letter p);
        return (p == NOTCH_A[w]) || (p == NOTCH_B[w]);
    endfunction

    function automatic t_letter wheel_fwd(t_wheel w, t_letter x);
        logic [7:0] ch;
        ch = WHEEL_WIRING[w][8 * (25 - int'(clamp25(x))) +: 8];
        return 5'(ch - 8'd65);
    endfunction

    function automatic t_letter wheel_inv(t_wheel w, t_letter x);
        t_letter y;
        y = 5'd0;
        for (int i = 0; i < LETTERS; i++) begin
            if (wheel_fwd(w, 5'(i)) == x) begin
                y = 5'(i);
            end
        end
        return y;
    endfunction

    function automatic t_letter reflect(logic sel, t_letter x);
        logic [7:0] ch;
        ch = REFLECTOR_WIRING[sel][8 * (25 - int'(clamp25(x))) +: 8];
        return 5'(ch - 8'd65);
    endfunction

    // One pass through a wheel; shift is position minus ring, mod 26.
    function automatic t_letter wheel_pass(t_wheel w, t_letter c, t_letter shift,
                                           logic rev);
        t_letter x;
        t_letter y;
        x = add26(c, shift);
        y = rev ? wheel_inv(w, x) : wheel_fwd(w, x);
        return sub26(y, shift);
    endfunction

    function automatic t_letter plug_end(t_letter v);
        return (v == UNPLUGGED) ? UNPLUGGED : clamp25(v);
    endfunction

    // Lowest-numbered complete wire holding the letter wins.
    function automatic t_letter plugboard(logic [PLUG_W-1:0] plugs, t_letter c);
        t_letter r;
        t_letter e0;
        t_letter e1;
        r = c;
        for (int w = WIRES - 1; w >= 0; w--) begin
            e0 = plug_end(plugs[10 * w +: 5]);
            e1 = plug_end(plugs[10 * w + 5 +: 5]);
            if (e0 == c && e1 != UNPLUGGED) begin
                r = e1;
            end else if (e1 == c && e0 != UNPLUGGED) begin
                r = e0;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/rce_in_if.sv
// Input channel of the rotor cipher letter engine: valid/ready plus one item.
// Depends on rce_pkg.
interface rce_in_if;
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    rce_pkg::t_letter letter_in;

    modport source (output valid, output opcode, output letter_in, input ready);
    modport sink   (input valid, input opcode, input letter_in, output ready);
endinterface

// File: rtl/rce_out_if.sv
// Result channel of the rotor cipher letter engine: valid/ready plus letter
// and rotor positions. Depends on rce_pkg.
interface rce_out_if;
    logic             valid;
    logic             ready;
    rce_pkg::t_letter letter_out;
    rce_pkg::t_letter left_position;
    rce_pkg::t_letter centre_position;
    rce_pkg::t_letter right_position;

    modport source (output valid, output letter_out, output left_position,
                    output centre_position, output right_position, input ready);
    modport sink   (input valid, input letter_out, input left_position,
                    input centre_position, input right_position, output ready);
endinterface

// File: rtl/rotor_cipher_letter_engine.sv
// Top level of the three-rotor letter engine (wheels I-VIII, reflector B/C,
// thirteen-wire plugboard). Depends on rce_pkg, rce_in_if and rce_out_if.
//
// Usage
//   i_in   : valid/ready channel carrying opcode and letter_in. Opcode
//            encode steps the rotors (with double step) and enciphers the
//            letter, undo restores the positions saved by the last
//            encode or load, load copies the start positions into current
//            and saved positions; the spare opcode only echoes the letter.
//   o_out  : one result per transfer: letter and the rotor positions after
//            the item.
//   i_cfg_*: register writes, one per cycle with i_cfg_we high, only while
//            the engine is empty.
// Items pass through pipeline stages 0 to 4 and the output register.
// Throughput: one letter per cycle unless the output is held. The rotor
// stepping is resolved in the input stage, so the position state never
// waits on the cipher path; substitution uses five stages, up to two wheel
// passes each. Reset: rotor positions go to A, registers to their defaults,
// pipeline empties. Stall: each full stage holds while the one after it is
// full and held; i_in.ready drops only once every stage up to the output is occupied.
module rotor_cipher_letter_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rce_in_if.sink                        i_in,
    rce_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rce_pkg::*;

    localparam int STAGES = 5;

    // Working item: pos/shift index 0 left, 1 centre, 2 right
    typedef struct packed {
        logic               enc;
        t_letter            ch;
        t_letter [0:2]      pos;
        t_letter [0:2]      shift;
    } t_pipe;

    // Configuration registers
    logic [8:0]        r_rotor_order;
    logic [14:0]       r_ring;
    logic [14:0]       r_start;
    logic              r_reflector;
    logic [PLUG_W-1:0] r_plugs;

    // Rotor state
    t_letter [0:2]     r_cur;
    t_letter [0:2]     r_saved;
    t_letter [0:2]     n_cur;
    t_letter [0:2]     n_saved;

    // Pipeline
    logic  [0:STAGES-1] r_pv;
    t_pipe [0:STAGES-1] r_pipe;
    t_pipe [0:STAGES-1] n_pipe;
    logic  [0:STAGES-1] stage_en;
    logic               out_en;
    logic               r_ov;
    t_pipe              r_out;
    t_pipe              n_out;

    logic              in_xfer;
    t_wheel [0:2]      wheel;
    t_letter [0:2]     ring;
    t_letter [0:2]     start;
    t_letter           letter;
    logic              notch_c;
    logic              notch_r;

    assign wheel = '{r_rotor_order[8:6], r_rotor_order[5:3], r_rotor_order[2:0]};
    assign ring  = '{clamp25(r_ring[14:10]), clamp25(r_ring[9:5]), clamp25(r_ring[4:0])};
    assign start = '{clamp25(r_start[14:10]), clamp25(r_start[9:5]),
                     clamp25(r_start[4:0])};

    // Backpressure: a stage loads when empty or when its successor moves on
    assign out_en = !r_ov || o_out.ready;
    always_comb begin
        stage_en[STAGES-1] = !r_pv[STAGES-1] || out_en;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_pv[k] || stage_en[k+1];
        end
    end

    assign i_in.ready = stage_en[0];
    assign in_xfer    = i_in.valid && stage_en[0];

    // Input stage: stepping and position bookkeeping
    always_comb begin
        letter  = clamp25(i_in.letter_in);
        notch_c = at_notch(wheel[1], r_cur[1]);
        notch_r = at_notch(wheel[2], r_cur[2]);
        n_cur   = r_cur;
        n_saved = r_saved;
        case (t_opcode'(i_in.opcode))
            OP_ENCODE: begin
                n_saved = r_cur;
                n_cur[0] = notch_c ? inc26(r_cur[0]) : r_cur[0];
                n_cur[1] = (notch_c || notch_r) ? inc26(r_cur[1]) : r_cur[1];
                n_cur[2] = inc26(r_cur[2]);
            end
            OP_UNDO: begin
                n_cur = r_saved;
            end
            OP_LOAD: begin
                n_cur   = start;
                n_saved = start;
            end
            default: begin
            end
        endcase
    end

    // Stage 0 payload, then the cipher path, two substitutions per stage
    always_comb begin
        n_pipe[0].enc = (t_opcode'(i_in.opcode) == OP_ENCODE);
        n_pipe[0].ch  = letter;
        n_pipe[0].pos = n_cur;
        for (int s = 0; s < 3; s++) begin
            n_pipe[0].shift[s] = sub26(n_cur[s], ring[s]);
        end

        for (int k = 1; k < STAGES; k++) begin
            n_pipe[k] = r_pipe[k-1];
        end
        if (r_pipe[0].enc) begin
            n_pipe[1].ch = wheel_pass(wheel[2],
                                      plugboard(r_plugs, r_pipe[0].ch),
                                      r_pipe[0].shift[2], 1'b0);
        end
        if (r_pipe[1].enc) begin
            n_pipe[2].ch = wheel_pass(wheel[0],
                                      wheel_pass(wheel[1], r_pipe[1].ch,
                                                 r_pipe[1].shift[1], 1'b0),
                                      r_pipe[1].shift[0], 1'b0);
        end
        if (r_pipe[2].enc) begin
            n_pipe[3].ch = wheel_pass(wheel[0], reflect(r_reflector, r_pipe[2].ch),
                                      r_pipe[2].shift[0], 1'b1);
        end
        if (r_pipe[3].enc) begin
            n_pipe[4].ch = wheel_pass(wheel[2],
                                      wheel_pass(wheel[1], r_pipe[3].ch,
                                                 r_pipe[3].shift[1], 1'b1),
                                      r_pipe[3].shift[2], 1'b1);
        end
        n_out = r_pipe[STAGES-1];
        if (r_pipe[STAGES-1].enc) begin
            n_out.ch = plugboard(r_plugs, r_pipe[STAGES-1].ch);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor_order <= 9'd10;
            r_ring        <= '0;
            r_start       <= '0;
            r_reflector   <= 1'b0;
            r_plugs       <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ROTOR_ORDER: r_rotor_order <= i_cfg_data[8:0];
                CFG_RING:        r_ring        <= i_cfg_data[14:0];
                CFG_START:       r_start       <= i_cfg_data[14:0];
                CFG_REFLECTOR:   r_reflector   <= i_cfg_data[0];
                CFG_PLUG_A:      r_plugs[49:0]    <= i_cfg_data[49:0];
                CFG_PLUG_B:      r_plugs[99:50]   <= i_cfg_data[49:0];
                CFG_PLUG_C:      r_plugs[129:100] <= i_cfg_data[29:0];
                default: begin
                end
            endcase
        end
    end

    // Rotor state moves only on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_saved <= '0;
        end else if (in_xfer) begin
            r_cur   <= n_cur;
            r_saved <= n_saved;
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_ov <= 1'b0;
        end else begin
            if (stage_en[0]) begin
                r_pv[0] <= i_in.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_en[k]) begin
                    r_pv[k] <= r_pv[k-1];
                end
            end
            if (out_en) begin
                r_ov <= r_pv[STAGES-1];
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
        if (out_en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.letter_out      = r_out.ch;
    assign o_out.left_position   = r_out.pos[0];
    assign o_out.centre_position = r_out.pos[1];
    assign o_out.right_position  = r_out.pos[2];

endmodule
